/* hw/rtl/jspl_pkg.sv */
// Shared types, widths and constants of the joint-space path length block.
`timescale 1ns / 1ps
package jspl_pkg;

  localparam int MAX_JOINTS = 6;
  localparam int ANGLE_BITS = 16;

  localparam int JC_BITS    = 3;
  localparam int JC_RESET   = 6;
  localparam int SEG_BITS   = 18;
  localparam int TOTAL_BITS = 40;

  // |a - b| of two signed angles fits in ANGLE_BITS unsigned bits
  localparam int MAG_BITS  = ANGLE_BITS;
  localparam int SQ_BITS   = 2 * MAG_BITS;
  localparam int SUM_BITS  = SQ_BITS + $clog2(MAX_JOINTS);
  localparam int ROOT_BITS = (SUM_BITS + 1) / 2;
  localparam int NPAIR     = (MAX_JOINTS + 1) / 2;

  localparam int IN_BITS  = ((MAX_JOINTS * ANGLE_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = ((SEG_BITS + TOTAL_BITS + 7) / 8) * 8;

  typedef logic signed [ANGLE_BITS-1:0] angle_t;
  typedef logic [SQ_BITS-1:0]           sq_t;
  typedef logic [SUM_BITS-1:0]          sum_t;
  typedef logic [ROOT_BITS-1:0]         root_t;
  typedef logic [JC_BITS-1:0]           jc_t;

endpackage

/* hw/rtl/jspl_lane.sv */
// One joint lane: keeps the previous angle, forms the difference magnitude and its square.
`timescale 1ns / 1ps
module jspl_lane (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  jspl_pkg::angle_t angle_i,
  output jspl_pkg::sq_t   sq_o
);
  import jspl_pkg::*;

  angle_t                    prev_q;
  logic [MAG_BITS-1:0]       mag_q, mag_d;
  sq_t                       sq_q;
  logic signed [ANGLE_BITS:0] diff;

  always_comb begin
    diff  = {angle_i[ANGLE_BITS-1], angle_i} - {prev_q[ANGLE_BITS-1], prev_q};
    mag_d = diff[ANGLE_BITS] ? MAG_BITS'(-diff) : MAG_BITS'(diff);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else if (load_i) begin
      prev_q <= angle_i;
    end
  end

  // payload only: the square is registered from the magnitude in the cycle after it
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      mag_q <= mag_d;
    end
    sq_q <= mag_q * mag_q;
  end

  assign sq_o = sq_q;

endmodule

/* hw/rtl/jspl_merge.sv */
// Merge stage: masks the lanes by joint count and sums their squares in a two-level tree.
`timescale 1ns / 1ps
module jspl_merge (
  input  logic                 clk_i,
  input  jspl_pkg::jc_t        joint_count_i,
  input  jspl_pkg::sq_t        sq_i [jspl_pkg::MAX_JOINTS],
  output jspl_pkg::sum_t       sum_o
);
  import jspl_pkg::*;

  logic [SQ_BITS:0] pair_q [NPAIR];
  logic [SQ_BITS:0] pair_d [NPAIR];
  sq_t              sq_pad [2*NPAIR];
  sum_t             sum_q, sum_d;
  int               used;

  always_comb begin
    used = int'(joint_count_i);
    if (used < 1) begin
      used = 1;
    end else if (used > MAX_JOINTS) begin
      used = MAX_JOINTS;
    end
    for (int j = 0; j < 2*NPAIR; j++) begin
      sq_pad[j] = '0;
    end
    for (int j = 0; j < MAX_JOINTS; j++) begin
      if (j < used) begin
        sq_pad[j] = sq_i[j];
      end
    end
    for (int p = 0; p < NPAIR; p++) begin
      pair_d[p] = {1'b0, sq_pad[2*p]} + {1'b0, sq_pad[2*p+1]};
    end
    sum_d = '0;
    for (int p = 0; p < NPAIR; p++) begin
      sum_d = sum_d + SUM_BITS'(pair_q[p]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int p = 0; p < NPAIR; p++) begin
      pair_q[p] <= pair_d[p];
    end
    sum_q <= sum_d;
  end

  assign sum_o = sum_q;

endmodule

/* hw/rtl/jspl_isqrt.sv */
// Digit-by-digit floor square root, one result bit per cycle.
`timescale 1ns / 1ps
module jspl_isqrt (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  jspl_pkg::sum_t  rad_i,
  input  logic            take_i,
  output logic            done_o,
  output jspl_pkg::root_t root_o
);
  import jspl_pkg::*;

  localparam int RAD_BITS = 2 * ROOT_BITS;
  localparam int REM_BITS = ROOT_BITS + 2;
  localparam int CNT_BITS = (ROOT_BITS > 1) ? $clog2(ROOT_BITS) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } state_e;

  state_e                state_q;
  logic [CNT_BITS-1:0]   cnt_q;
  logic [RAD_BITS-1:0]   rad_q;
  logic [REM_BITS-1:0]   rem_q, rem_d;
  root_t                 root_q, root_d;
  logic [REM_BITS+1:0]   shifted, trial;

  always_comb begin
    shifted = {rem_q, rad_q[RAD_BITS-1 -: 2]};
    trial   = (REM_BITS+2)'({root_q, 2'b01});
    if (shifted >= trial) begin
      rem_d  = REM_BITS'(shifted - trial);
      root_d = {root_q[ROOT_BITS-2:0], 1'b1};
    end else begin
      rem_d  = REM_BITS'(shifted);
      root_d = {root_q[ROOT_BITS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      rad_q   <= '0;
      rem_q   <= '0;
      root_q  <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            rad_q   <= RAD_BITS'(rad_i);
            rem_q   <= '0;
            root_q  <= '0;
            cnt_q   <= CNT_BITS'(ROOT_BITS - 1);
            state_q <= S_RUN;
          end
        end
        S_RUN: begin
          rad_q  <= {rad_q[RAD_BITS-3:0], 2'b00};
          rem_q  <= rem_d;
          root_q <= root_d;
          cnt_q  <= cnt_q - 1'b1;
          if (cnt_q == '0) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (take_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign done_o = (state_q == S_DONE);
  assign root_o = root_q;

endmodule

/* hw/rtl/joint_space_path_length.sv */
// Top level: stream ports, joint lanes, merge tree, square root and running total.
`timescale 1ns / 1ps
// Joint-space path length. Each input item is one trajectory point: six signed Q4.12
// joint angles in s_tdata_i and the start flag in s_tuser_i. Every item gives one
// result with the segment length to the previous point (Q.12, floor of the Euclidean
// distance over the first joint_count joints, zero on a start or the first point after
// reset), the saturating 40-bit running total and a sticky saturation flag. The block
// is not ready from accepting an item until its result moves to the output register.
// Lane difference magnitudes are registered, then their squares, two merge tree levels
// and the square root unit, which settles one result bit per cycle; last the total is
// updated and the output register loaded, a step that waits while an earlier result is
// unread. The next item is accepted while a result waits in that register. joint_count
// is to be written through the cfg channel only while the block is idle; the block does
// not enforce this. 0 acts as 1 and values above 6 act as 6.
module joint_space_path_length (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_tvalid_i,
  output logic                          s_tready_o,
  // joint_0 .. joint_5, 16 bits each, joint_0 lowest
  input  logic [jspl_pkg::IN_BITS-1:0]  s_tdata_i,
  // start_req
  input  logic                          s_tuser_i,
  output logic                          m_tvalid_o,
  input  logic                          m_tready_i,
  // segment_length [17:0], total_length [57:18], zero fill
  output logic [jspl_pkg::OUT_BITS-1:0] m_tdata_o,
  // saturated
  output logic                          m_tuser_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  jspl_pkg::jc_t                 cfg_data_i
);
  import jspl_pkg::*;

  localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;

  jc_t                   jc_q;
  logic                  busy_q;
  logic [3:0]            pipe_q;
  logic                  clear_q, zero_q, have_prev_q;
  logic [TOTAL_BITS-1:0] total_q, total_d;
  logic                  sat_q, sat_d;
  logic                  m_tvalid_q;
  logic [SEG_BITS-1:0]   seg_q, seg_d;

  logic                  accept, take, root_done;
  sq_t                   sq [MAX_JOINTS];
  sum_t                  sum;
  root_t                 root;
  logic [TOTAL_BITS-1:0] base;
  logic [TOTAL_BITS:0]   acc;

  assign accept      = s_tvalid_i && s_tready_o;
  assign s_tready_o  = !busy_q;
  assign cfg_ready_o = 1'b1;

  for (genvar j = 0; j < MAX_JOINTS; j++) begin : g_lane
    jspl_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .load_i  (accept),
      .angle_i (angle_t'(s_tdata_i[j*ANGLE_BITS +: ANGLE_BITS])),
      .sq_o    (sq[j])
    );
  end

  jspl_merge u_merge (
    .clk_i         (clk_i),
    .joint_count_i (jc_q),
    .sq_i          (sq),
    .sum_o         (sum)
  );

  jspl_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (pipe_q[3]),
    .rad_i   (sum),
    .take_i  (take),
    .done_o  (root_done),
    .root_o  (root)
  );

  // move the root into the output register once it is free
  assign take = root_done && (!m_tvalid_q || m_tready_i);

  always_comb begin
    seg_d = zero_q ? '0 : SEG_BITS'(root);
    base  = clear_q ? '0 : total_q;
    sat_d = clear_q ? 1'b0 : sat_q;
    acc   = {1'b0, base} + (TOTAL_BITS+1)'(seg_d);
    if (acc[TOTAL_BITS]) begin
      total_d = TOTAL_MAX;
      sat_d   = 1'b1;
    end else begin
      total_d = acc[TOTAL_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      jc_q        <= jc_t'(JC_RESET);
      busy_q      <= 1'b0;
      pipe_q      <= '0;
      clear_q     <= 1'b0;
      zero_q      <= 1'b0;
      have_prev_q <= 1'b0;
      total_q     <= '0;
      sat_q       <= 1'b0;
      m_tvalid_q  <= 1'b0;
      seg_q       <= '0;
    end else begin
      if (cfg_valid_i) begin
        jc_q <= cfg_data_i;
      end
      pipe_q <= {pipe_q[2:0], accept};
      if (accept) begin
        busy_q      <= 1'b1;
        clear_q     <= s_tuser_i;
        zero_q      <= s_tuser_i || !have_prev_q;
        have_prev_q <= 1'b1;
      end
      if (take) begin
        busy_q     <= 1'b0;
        total_q    <= total_d;
        sat_q      <= sat_d;
        seg_q      <= seg_d;
        m_tvalid_q <= 1'b1;
      end else if (m_tready_i) begin
        m_tvalid_q <= 1'b0;
      end
    end
  end

  assign m_tvalid_o = m_tvalid_q;
  assign m_tdata_o  = {(OUT_BITS-SEG_BITS-TOTAL_BITS)'(0), total_q, seg_q};
  assign m_tuser_o  = sat_q;

endmodule
